// ----- hw/rtl/nsd_pkg.sv -----
// Shared types and constants of the NCC stereo disparity unit.
`timescale 1ns / 1ps
package nsd_pkg;

  typedef enum logic [8:0] {
    ST_IDLE = 9'b000000001,
    ST_DISP = 9'b000000010,
    ST_ACC  = 9'b000000100,
    ST_MUL  = 9'b000001000,
    ST_SQRT = 9'b000010000,
    ST_PREP = 9'b000100000,
    ST_DIV  = 9'b001000000,
    ST_CMP  = 9'b010000000,
    ST_DONE = 9'b100000000
  } nsd_state_e;

  typedef enum logic [1:0] {
    REG_WIDTH  = 2'd0,
    REG_DMIN   = 2'd1,
    REG_DMAX   = 2'd2,
    REG_THRESH = 2'd3
  } nsd_reg_e;

  localparam logic [10:0]        RST_WIDTH  = 11'd640;
  localparam logic signed [6:0]  RST_DMIN   = -7'sd30;
  localparam logic signed [6:0]  RST_DMAX   = -7'sd7;
  localparam logic signed [15:0] RST_THRESH = -16'sd32768;

  localparam logic signed [15:0] SCORE_MIN = -16'sd32768;
  localparam logic signed [15:0] SCORE_MAX = 16'sd32767;
  localparam int unsigned        SCORE_SCALE_SHIFT = 16;

endpackage

// ----- hw/rtl/ncc_stereo_disparity_unit.sv -----
// Top level of the NCC stereo disparity unit: line stores, sequencer and shared datapath.
// Sequence: a border pixel is taken with no result; else each disparity in range is skipped
//   if its right window would leave the line, or scored by dispatch, window reads, multiply
//   steps, sqrt steps, a prep step, divide steps and a compare.
// Throughput: one pixel at a time; in_ready_o is high only while the sequencer idles, and a
//   stalled result holds the sequencer. The window sums share one read port per line store;
//   the products of NQ_W-bit operands share one multiplier.
// Reset clears state, counters, config and handshakes, not the datapath or line stores.
`timescale 1ns / 1ps
module ncc_stereo_disparity_unit
  import nsd_pkg::*;
#(
  parameter int MAX_WIDTH     = 1024,
  parameter int WINDOW_RADIUS = 4
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  logic [7:0]          left_pixel_i,
  input  logic [7:0]          right_pixel_i,
  input  logic                frame_start_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output logic [9:0]          column_o,
  output logic [11:0]         row_o,
  output logic signed [6:0]   disparity_o,
  output logic                found_o,
  output logic signed [15:0]  score_o,
  output logic                is_seed_o,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [3:0]          paddr,
  input  logic [31:0]         pwdata,
  output logic [31:0]         prdata,
  output logic                pready
);

  localparam int WIN_SIDE = 2 * WINDOW_RADIUS + 1;
  localparam int WIN_AREA = WIN_SIDE * WIN_SIDE;
  localparam int DEPTH    = WIN_SIDE * MAX_WIDTH;
  localparam int ADDR_W   = $clog2(DEPTH);
  localparam int COL_W    = $clog2(MAX_WIDTH);
  localparam int WID_W    = $clog2(MAX_WIDTH + 1);
  localparam int SLOT_W   = $clog2(WIN_SIDE);
  localparam int CNT_W    = $clog2(WIN_AREA + 1);
  localparam int SUM_W    = $clog2(WIN_AREA * 255 + 1);
  localparam int SQ_W     = $clog2(WIN_AREA * 65025 + 1);
  localparam int NQ_W     = $clog2(64'(WIN_AREA) * 64'(WIN_AREA) * 64'd65025 + 64'd1);
  localparam int DEN_W    = NQ_W + 4;
  localparam int DVS_W    = DEN_W + 1;
  localparam int DIV_W    = NQ_W + 21;
  localparam int SC_W     = $clog2(NQ_W);
  localparam int DC_W     = $clog2(DIV_W);

  nsd_state_e state_q, state_d;

  logic [COL_W-1:0]  col_q;
  logic [11:0]       row_q;
  logic [SLOT_W-1:0] rmod_q;
  logic              out_vld_q;
  logic              rdv_q;

  logic [10:0]        cfg_w_q;
  logic signed [6:0]  cfg_dmin_q;
  logic signed [6:0]  cfg_dmax_q;
  logic signed [15:0] cfg_thr_q;

  logic [COL_W-1:0]   x_q, xlb_q, xrb_q, coll_q, colr_q;
  logic [11:0]        rowc_q;
  logic [SLOT_W-1:0]  sstart_q, slot_q, k_q;
  logic signed [7:0]  dhi_q, d_q;
  logic signed [15:0] best_q;
  logic signed [7:0]  bestd_q;
  logic               found_q;
  logic [CNT_W-1:0]   iss_q;
  logic [SUM_W-1:0]   s1_q, s2_q;
  logic [SQ_W-1:0]    q1_q, q2_q, xp_q;
  logic [2:0]         mstep_q;
  logic [2*NQ_W-1:0]  prod_q;
  logic               neg_q;
  logic [NQ_W-1:0]    mag_q, v1_q, v2_q;
  logic [2*NQ_W-1:0]  sqop_q;
  logic [NQ_W+1:0]    sqrem_q;
  logic [NQ_W-1:0]    sqroot_q;
  logic [SC_W-1:0]    scnt_q;
  logic [DVS_W-1:0]   dvsr_q, dr_q;
  logic [DIV_W-1:0]   dv_q;
  logic [DC_W-1:0]    dcnt_q;

  logic [9:0]         col_o_q;
  logic [11:0]        row_o_q;
  logic signed [6:0]  disp_o_q;
  logic               found_o_q, seed_o_q;
  logic signed [15:0] score_o_q;

  logic [7:0] lmem [DEPTH];
  logic [7:0] rmem [DEPTH];
  logic [7:0] l_rd_q, r_rd_q;

  logic              in_acc, out_load, cfg_wr, rd_en, produce, wrap;
  logic [12:0]       w_wide;
  logic [WID_W-1:0]  w_eff;
  logic [COL_W-1:0]  col_raw, col_eff;
  logic [COL_W:0]    col_inc;
  logic [11:0]       row_eff;
  logic [SLOT_W-1:0] rmod_eff;
  logic signed [7:0] dlo;
  logic signed [15:0] xr_s;
  logic [ADDR_W-1:0] waddr, raddr_l, raddr_r;
  logic [15:0]       p_ll, p_rr, p_lr;
  logic [NQ_W-1:0]   mul_a, mul_b, nxp, nq1, nq2;
  logic [2*NQ_W-1:0] mul_res;
  logic [NQ_W:0]     diff;
  logic [NQ_W+2:0]   rem_sh, trial;
  logic [DVS_W:0]    dr_sh;
  logic [DEN_W-1:0]  den;
  logic [DIV_W-1:0]  dividend, mag_scaled;
  logic signed [15:0] score_s;

  assign in_ready_o = (state_q == ST_IDLE);
  assign in_acc     = in_valid_i && in_ready_o;
  assign out_load   = (state_q == ST_DONE) && (!out_vld_q || out_ready_i);
  assign cfg_wr     = psel && penable && pwrite && pready;
  assign pready     = 1'b1;
  assign rd_en      = (state_q == ST_ACC) && (iss_q != CNT_W'(WIN_AREA));

  assign w_wide = 13'(cfg_w_q);
  always_comb begin
    if (w_wide == 13'd0) begin
      w_eff = WID_W'(1);
    end else if (w_wide > 13'(MAX_WIDTH)) begin
      w_eff = WID_W'(MAX_WIDTH);
    end else begin
      w_eff = WID_W'(w_wide);
    end
  end

  assign col_raw  = frame_start_i ? '0 : col_q;
  assign col_eff  = (WID_W'(col_raw) >= w_eff) ? '0 : col_raw;
  assign row_eff  = frame_start_i ? '0 : row_q;
  assign rmod_eff = frame_start_i ? '0 : rmod_q;
  assign produce  = (row_eff >= 12'(2 * WINDOW_RADIUS)) &&
                    (col_eff >= COL_W'(2 * WINDOW_RADIUS));
  assign col_inc  = (COL_W + 1)'(col_eff) + (COL_W + 1)'(1);
  assign wrap     = col_inc >= (COL_W + 1)'(w_eff);
  assign dlo      = 8'(cfg_dmin_q);
  assign xr_s     = signed'(16'(xlb_q)) + 16'(d_q);

  assign waddr   = ADDR_W'(rmod_eff) * ADDR_W'(MAX_WIDTH) + ADDR_W'(col_eff);
  assign raddr_l = ADDR_W'(slot_q) * ADDR_W'(MAX_WIDTH) + ADDR_W'(coll_q);
  assign raddr_r = ADDR_W'(slot_q) * ADDR_W'(MAX_WIDTH) + ADDR_W'(colr_q);

  assign p_ll = 16'(l_rd_q) * 16'(l_rd_q);
  assign p_rr = 16'(r_rd_q) * 16'(r_rd_q);
  assign p_lr = 16'(l_rd_q) * 16'(r_rd_q);

  always_comb begin
    unique case (mstep_q)
      3'd0:    begin mul_a = NQ_W'(s1_q); mul_b = NQ_W'(s2_q); end
      3'd1:    begin mul_a = NQ_W'(s1_q); mul_b = NQ_W'(s1_q); end
      3'd2:    begin mul_a = NQ_W'(s2_q); mul_b = NQ_W'(s2_q); end
      default: begin mul_a = v1_q;        mul_b = v2_q;        end
    endcase
  end
  assign mul_res = (2 * NQ_W)'(mul_a) * (2 * NQ_W)'(mul_b);

  assign nxp = NQ_W'(xp_q) * NQ_W'(WIN_AREA);
  assign nq1 = NQ_W'(q1_q) * NQ_W'(WIN_AREA);
  assign nq2 = NQ_W'(q2_q) * NQ_W'(WIN_AREA);

  always_comb begin
    unique case (mstep_q)
      3'd1:    diff = {1'b0, nxp} - {1'b0, prod_q[NQ_W-1:0]};
      3'd2:    diff = {1'b0, nq1} - {1'b0, prod_q[NQ_W-1:0]};
      default: diff = {1'b0, nq2} - {1'b0, prod_q[NQ_W-1:0]};
    endcase
  end

  assign rem_sh = {sqrem_q[NQ_W:0], sqop_q[2*NQ_W-1 -: 2]};
  assign trial  = {1'b0, sqroot_q, 2'b01};
  assign dr_sh  = {dr_q, dv_q[DIV_W-1]};

  assign den        = DEN_W'(sqroot_q) * DEN_W'(10) + DEN_W'(WIN_AREA);
  assign mag_scaled = ((DIV_W'(mag_q) << 2) + DIV_W'(mag_q)) << SCORE_SCALE_SHIFT;
  assign dividend   = (mag_scaled << 1) + DIV_W'(den);

  always_comb begin
    if (neg_q) begin
      score_s = (dv_q > DIV_W'(32768)) ? SCORE_MIN : -signed'(16'(dv_q));
    end else begin
      score_s = (dv_q > DIV_W'(32767)) ? SCORE_MAX : signed'(16'(dv_q));
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: if (in_acc && produce) state_d = ST_DISP;
      ST_DISP: begin
        if (d_q > dhi_q) begin
          state_d = ST_DONE;
        end else if (xr_s >= 16'sd0) begin
          state_d = ST_ACC;
        end
      end
      ST_ACC:  if (iss_q == CNT_W'(WIN_AREA) && !rdv_q) state_d = ST_MUL;
      ST_MUL:  if (mstep_q == 3'd5) state_d = ST_SQRT;
      ST_SQRT: if (scnt_q == SC_W'(NQ_W - 1)) state_d = ST_PREP;
      ST_PREP: state_d = ST_DIV;
      ST_DIV:  if (dcnt_q == DC_W'(DIV_W - 1)) state_d = ST_CMP;
      ST_CMP:  state_d = ST_DISP;
      ST_DONE: if (out_load) state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_IDLE;
      col_q      <= '0;
      row_q      <= '0;
      rmod_q     <= '0;
      out_vld_q  <= 1'b0;
      rdv_q      <= 1'b0;
      cfg_w_q    <= RST_WIDTH;
      cfg_dmin_q <= RST_DMIN;
      cfg_dmax_q <= RST_DMAX;
      cfg_thr_q  <= RST_THRESH;
    end else begin
      state_q <= state_d;
      rdv_q   <= rd_en;
      if (out_load) begin
        out_vld_q <= 1'b1;
      end else if (out_ready_i) begin
        out_vld_q <= 1'b0;
      end
      if (in_acc) begin
        if (wrap) begin
          col_q <= '0;
          row_q <= row_eff + 12'd1;
          rmod_q <= (row_eff == 12'hFFF || rmod_eff == SLOT_W'(2 * WINDOW_RADIUS)) ?
                    '0 : rmod_eff + SLOT_W'(1);
        end else begin
          col_q  <= col_inc[COL_W-1:0];
          row_q  <= row_eff;
          rmod_q <= rmod_eff;
        end
      end
      if (cfg_wr) begin
        unique case (nsd_reg_e'(paddr[3:2]))
          REG_WIDTH:  cfg_w_q    <= pwdata[10:0];
          REG_DMIN:   cfg_dmin_q <= pwdata[6:0];
          REG_DMAX:   cfg_dmax_q <= pwdata[6:0];
          REG_THRESH: cfg_thr_q  <= pwdata[15:0];
          default:    cfg_w_q    <= cfg_w_q;
        endcase
      end
    end
  end

  always_comb begin
    unique case (nsd_reg_e'(paddr[3:2]))
      REG_WIDTH:  prdata = 32'(cfg_w_q);
      REG_DMIN:   prdata = 32'(unsigned'(cfg_dmin_q));
      REG_DMAX:   prdata = 32'(unsigned'(cfg_dmax_q));
      REG_THRESH: prdata = 32'(unsigned'(cfg_thr_q));
      default:    prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      lmem[waddr] <= left_pixel_i;
      rmem[waddr] <= right_pixel_i;
    end
    if (rd_en) begin
      l_rd_q <= lmem[raddr_l];
      r_rd_q <= rmem[raddr_r];
    end
  end

  always_ff @(posedge clk_i) begin
    unique case (state_q)
      ST_IDLE: begin
        if (in_acc) begin
          x_q      <= col_eff - COL_W'(WINDOW_RADIUS);
          xlb_q    <= col_eff - COL_W'(2 * WINDOW_RADIUS);
          rowc_q   <= row_eff - 12'(WINDOW_RADIUS);
          sstart_q <= (rmod_eff == SLOT_W'(2 * WINDOW_RADIUS)) ? '0 : rmod_eff + SLOT_W'(1);
          dhi_q    <= cfg_dmax_q[6] ? 8'(cfg_dmax_q) : 8'sd0;
          d_q      <= dlo;
          best_q   <= SCORE_MIN;
          bestd_q  <= 8'sd0;
          found_q  <= 1'b0;
        end
      end
      ST_DISP: begin
        iss_q  <= '0;
        k_q    <= '0;
        slot_q <= sstart_q;
        coll_q <= xlb_q;
        colr_q <= xr_s[COL_W-1:0];
        xrb_q  <= xr_s[COL_W-1:0];
        s1_q   <= '0;
        s2_q   <= '0;
        q1_q   <= '0;
        q2_q   <= '0;
        xp_q   <= '0;
        if (d_q <= dhi_q && xr_s < 16'sd0) begin
          d_q <= d_q + 8'sd1;
        end
      end
      ST_ACC: begin
        mstep_q <= '0;
        if (rd_en) begin
          iss_q <= iss_q + CNT_W'(1);
          if (k_q == SLOT_W'(2 * WINDOW_RADIUS)) begin
            k_q    <= '0;
            slot_q <= (slot_q == SLOT_W'(2 * WINDOW_RADIUS)) ? '0 : slot_q + SLOT_W'(1);
            coll_q <= xlb_q;
            colr_q <= xrb_q;
          end else begin
            k_q    <= k_q + SLOT_W'(1);
            coll_q <= coll_q + COL_W'(1);
            colr_q <= colr_q + COL_W'(1);
          end
        end
        if (rdv_q) begin
          s1_q <= s1_q + SUM_W'(l_rd_q);
          s2_q <= s2_q + SUM_W'(r_rd_q);
          q1_q <= q1_q + SQ_W'(p_ll);
          q2_q <= q2_q + SQ_W'(p_rr);
          xp_q <= xp_q + SQ_W'(p_lr);
        end
      end
      ST_MUL: begin
        mstep_q <= mstep_q + 3'd1;
        prod_q  <= mul_res;
        unique case (mstep_q)
          3'd1: begin
            neg_q <= diff[NQ_W];
            mag_q <= diff[NQ_W] ? NQ_W'(~diff + 1'b1) : diff[NQ_W-1:0];
          end
          3'd2: v1_q <= diff[NQ_W] ? '0 : diff[NQ_W-1:0];
          3'd3: v2_q <= diff[NQ_W] ? '0 : diff[NQ_W-1:0];
          3'd5: begin
            sqop_q   <= prod_q;
            sqrem_q  <= '0;
            sqroot_q <= '0;
            scnt_q   <= '0;
          end
          default: neg_q <= neg_q;
        endcase
      end
      ST_SQRT: begin
        sqop_q <= sqop_q << 2;
        scnt_q <= scnt_q + SC_W'(1);
        if (rem_sh >= trial) begin
          sqrem_q  <= (NQ_W + 2)'(rem_sh - trial);
          sqroot_q <= {sqroot_q[NQ_W-2:0], 1'b1};
        end else begin
          sqrem_q  <= rem_sh[NQ_W+1:0];
          sqroot_q <= {sqroot_q[NQ_W-2:0], 1'b0};
        end
      end
      ST_PREP: begin
        dvsr_q <= {den, 1'b0};
        dv_q   <= dividend;
        dr_q   <= '0;
        dcnt_q <= '0;
      end
      ST_DIV: begin
        dcnt_q <= dcnt_q + DC_W'(1);
        if (dr_sh >= {1'b0, dvsr_q}) begin
          dr_q <= DVS_W'(dr_sh - {1'b0, dvsr_q});
          dv_q <= {dv_q[DIV_W-2:0], 1'b1};
        end else begin
          dr_q <= dr_sh[DVS_W-1:0];
          dv_q <= {dv_q[DIV_W-2:0], 1'b0};
        end
      end
      ST_CMP: begin
        d_q <= d_q + 8'sd1;
        if (score_s > best_q) begin
          best_q  <= score_s;
          bestd_q <= d_q;
          found_q <= 1'b1;
        end
      end
      ST_DONE: begin
        if (out_load) begin
          col_o_q   <= 10'(x_q);
          row_o_q   <= rowc_q;
          disp_o_q  <= 7'(bestd_q);
          found_o_q <= found_q;
          score_o_q <= best_q;
          seed_o_q  <= found_q && (best_q >= cfg_thr_q);
        end
      end
      default: found_q <= found_q;
    endcase
  end

  assign out_valid_o = out_vld_q;
  assign column_o    = col_o_q;
  assign row_o       = row_o_q;
  assign disparity_o = disp_o_q;
  assign found_o     = found_o_q;
  assign score_o     = score_o_q;
  assign is_seed_o   = seed_o_q;

  a_state_onehot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot(state_q))
    else $error("sequencer state not one-hot");

  a_not_found_fields: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !found_o |-> score_o == SCORE_MIN && disparity_o == 7'sd0)
    else $error("result without match carries a score or disparity");

  a_seed_needs_found: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && is_seed_o |-> found_o)
    else $error("seed flagged without a match");

  a_issue_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_ACC |-> iss_q <= CNT_W'(WIN_AREA))
    else $error("window read count overran");

  a_cmp_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_CMP |-> d_q <= dhi_q && d_q >= dlo)
    else $error("disparity scored outside its range");

endmodule

// ----- tb/sv/tb_top.sv -----
// Testbench for the NCC stereo disparity unit: directed and random frames checked against a predictor.
`timescale 1ns / 1ps
module tb_top;
  import nsd_pkg::*;

  localparam int RAD = 4;
  localparam int SIDE = 2 * RAD + 1;
  localparam int AREA = SIDE * SIDE;
  localparam int MAXW = 1024;
  localparam longint CYCLE_LIMIT = 8000000;

  typedef struct {
    logic [9:0]         column;
    logic [11:0]        row;
    logic signed [6:0]  disparity;
    logic               found;
    logic signed [15:0] score;
    logic               is_seed;
  } match_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic in_ready_o;
  logic [7:0] left_pixel_i = '0;
  logic [7:0] right_pixel_i = '0;
  logic frame_start_i = 1'b0;
  logic out_valid_o;
  logic out_ready_i = 1'b0;
  logic [9:0] column_o;
  logic [11:0] row_o;
  logic signed [6:0] disparity_o;
  logic found_o;
  logic signed [15:0] score_o;
  logic is_seed_o;
  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [3:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;

  ncc_stereo_disparity_unit dut (.*);

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // predictor state
  byte unsigned left_store[SIDE * MAXW];
  byte unsigned right_store[SIDE * MAXW];
  int unsigned col_cnt, row_cnt;
  logic [10:0] cfg_width;
  logic [6:0] cfg_dmin, cfg_dmax;
  logic [15:0] cfg_thresh;

  match_t expected_matches[$];
  int err_count = 0;
  longint cycle_count = 0;
  bit no_idle = 1'b0;
  bit hold_req = 1'b0;
  int hold_left = 0;
  int pixels_sent = 0;

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  // receiver with random stalls and one long hold-off
  always @(posedge clk_i) begin
    if (hold_req) begin
      hold_req = 1'b0;
      hold_left = 3000;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_ready_i <= 1'b0;
    end else if (no_idle) begin
      out_ready_i <= 1'b1;
    end else begin
      out_ready_i <= ($urandom_range(99) >= 19);
    end
  end

  always @(posedge clk_i) begin
    match_t e;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (expected_matches.size() == 0) begin
        $error("unexpected result at row %0d column %0d", row_o, column_o);
        err_count++;
      end else begin
        e = expected_matches.pop_front();
        if (column_o !== e.column) begin
          $error("column: expected %0d actual %0d", e.column, column_o); err_count++;
        end
        if (row_o !== e.row) begin
          $error("row: expected %0d actual %0d", e.row, row_o); err_count++;
        end
        if (disparity_o !== e.disparity) begin
          $error("disparity: expected %0d actual %0d", e.disparity, disparity_o);
          err_count++;
        end
        if (found_o !== e.found) begin
          $error("found: expected %0d actual %0d", e.found, found_o); err_count++;
        end
        if (score_o !== e.score) begin
          $error("score: expected %0d actual %0d", e.score, score_o); err_count++;
        end
        if (is_seed_o !== e.is_seed) begin
          $error("is_seed: expected %0d actual %0d", e.is_seed, is_seed_o); err_count++;
        end
      end
    end
  end

  function automatic longint unsigned int_sqrt(longint unsigned v);
    longint unsigned r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > v) b >>= 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v -= r + b;
        r = (r >> 1) + b;
      end else begin
        r >>= 1;
      end
      b >>= 2;
    end
    return r;
  endfunction

  function automatic int window_ncc(int unsigned x, int d);
    longint s1, s2, q1, q2, xp, a, b, num, v1, v2, sc;
    longint unsigned den, mag, q;
    int unsigned slot, cl, cr;
    s1 = 0; s2 = 0; q1 = 0; q2 = 0; xp = 0;
    for (int i = 0; i < SIDE; i++) begin
      slot = (row_cnt % SIDE + SIDE - 2 * RAD + i) % SIDE;
      for (int k = 0; k < SIDE; k++) begin
        cl = (x + k - RAD) % MAXW;
        cr = (int'(x) + d + k - RAD) % MAXW;
        a = left_store[slot * MAXW + cl];
        b = right_store[slot * MAXW + cr];
        s1 += a; s2 += b; q1 += a * a; q2 += b * b; xp += a * b;
      end
    end
    num = AREA * xp - s1 * s2;
    v1 = AREA * q1 - s1 * s1;
    v2 = AREA * q2 - s2 * s2;
    if (v1 < 0) v1 = 0;
    if (v2 < 0) v2 = 0;
    den = 10 * int_sqrt(longint'(v1) * longint'(v2)) + AREA;
    sc = num * 327680;
    mag = (sc < 0) ? -sc : sc;
    q = (2 * mag + den) / (2 * den);
    if (sc < 0) return (q > 32768) ? -32768 : -int'(q);
    return (q > 32767) ? 32767 : int'(q);
  endfunction

  task automatic predict_pixel(byte unsigned l, byte unsigned r, bit fs);
    int unsigned w, addr, x;
    int dlo, dhi, best, best_d, s;
    bit found;
    match_t e;
    w = (cfg_width == 0) ? 1 : ((cfg_width > MAXW) ? MAXW : cfg_width);
    if (fs) begin
      col_cnt = 0;
      row_cnt = 0;
    end
    if (col_cnt >= w) col_cnt = 0;
    addr = (row_cnt % SIDE) * MAXW + col_cnt;
    left_store[addr] = l;
    right_store[addr] = r;
    if (row_cnt >= 2 * RAD && col_cnt >= 2 * RAD) begin
      x = col_cnt - RAD;
      dlo = int'($signed(cfg_dmin));
      dhi = int'($signed(cfg_dmax));
      if (dhi > 0) dhi = 0;
      best = -32768;
      best_d = 0;
      found = 1'b0;
      for (int d = dlo; d <= dhi; d++) begin
        if (int'(x) + d - RAD < 0) continue;
        s = window_ncc(x, d);
        if (s > best) begin
          best = s;
          best_d = d;
          found = 1'b1;
        end
      end
      e.column = x[9:0];
      e.row = 12'(row_cnt - RAD);
      e.disparity = 7'(best_d);
      e.found = found;
      e.score = 16'(best);
      e.is_seed = found && (best >= int'($signed(cfg_thresh)));
      expected_matches.insert(expected_matches.size(), e);
    end
    col_cnt++;
    if (col_cnt >= w) begin
      col_cnt = 0;
      row_cnt = (row_cnt + 1) & 12'hFFF;
    end
  endtask

  task automatic send_pixel(byte unsigned l, byte unsigned r, bit fs);
    if (!no_idle && $urandom_range(99) < 19) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    left_pixel_i <= l;
    right_pixel_i <= r;
    frame_start_i <= fs;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    predict_pixel(l, r, fs);
    pixels_sent++;
  endtask

  task automatic drain;
    in_valid_i <= 1'b0;
    while (expected_matches.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
  endtask

  task automatic write_reg(nsd_reg_e idx, logic [31:0] val);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= val;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel <= 1'b0;
    penable <= 1'b0;
    case (idx)
      REG_WIDTH:  cfg_width = val[10:0];
      REG_DMIN:   cfg_dmin = val[6:0];
      REG_DMAX:   cfg_dmax = val[6:0];
      REG_THRESH: cfg_thresh = val[15:0];
      default: ;
    endcase
  endtask

  task automatic read_reg(nsd_reg_e idx, int bits, logic [31:0] want);
    logic [31:0] mask;
    mask = (32'd1 << bits) - 1;
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b0;
    paddr <= {idx, 2'b00};
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    if ((prdata & mask) !== (want & mask)) begin
      $error("%s: expected %0h actual %0h", idx.name(), want & mask, prdata & mask);
      err_count++;
    end
    psel <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic configure(int w, int dmin, int dmax, int thr);
    drain();
    write_reg(REG_WIDTH, 32'(w));
    write_reg(REG_DMIN, 32'(dmin));
    write_reg(REG_DMAX, 32'(dmax));
    write_reg(REG_THRESH, 32'(thr));
  endtask

  // one frame; right row is the left row moved by shift, plus noise where asked, or the inverted left row in mode 4
  task automatic send_frame(int w, int rows, int shift, int noise_pct, int pix_mode);
    byte unsigned lrow[MAXW + 64];
    byte unsigned rrow;
    for (int y = 0; y < rows; y++) begin
      for (int c = 0; c < w + 64; c++) begin
        case (pix_mode)
          1: lrow[c] = 8'h00;
          2: lrow[c] = 8'hFF;
          3: lrow[c] = ((c + y) % 2) ? 8'hFF : 8'h00;
          default: lrow[c] = 8'($urandom_range(255));
        endcase
      end
      for (int c = 0; c < w; c++) begin
        rrow = ($urandom_range(99) < noise_pct) ? 8'($urandom_range(255)) : lrow[c + shift];
        if (pix_mode == 4) rrow = ~lrow[c];
        send_pixel(lrow[c], rrow, (y == 0 && c == 0));
      end
    end
  endtask

  task automatic test_register_access;
    read_reg(REG_WIDTH, 11, 32'(RST_WIDTH));
    read_reg(REG_DMIN, 7, 32'(RST_DMIN));
    read_reg(REG_DMAX, 7, 32'(RST_DMAX));
    read_reg(REG_THRESH, 16, 32'(RST_THRESH));
    write_reg(REG_WIDTH, 32'd1023);
    write_reg(REG_DMIN, 32'h55);
    write_reg(REG_DMAX, 32'h2A);
    write_reg(REG_THRESH, 32'hA5A5);
    read_reg(REG_WIDTH, 11, 32'd1023);
    read_reg(REG_DMIN, 7, 32'h55);
    read_reg(REG_DMAX, 7, 32'h2A);
    read_reg(REG_THRESH, 16, 32'hA5A5);
  endtask

  task automatic test_corner_frames;
    configure(9, -64, 5, -32768);
    send_frame(9, 9, 0, 0, 1);
    send_frame(9, 9, 0, 0, 2);
    configure(9, -64, 0, 32767);
    send_frame(9, 10, 0, 0, 3);
    send_frame(9, 9, 0, 0, 4);
    configure(9, 0, 0, 0);
    send_frame(9, 9, 0, 100, 0);
    configure(0, -1, -1, 0);
    send_frame(1, 3, 0, 0, 0);
    configure(8, -2, 0, 0);
    send_frame(8, 10, 0, 0, 0);
    configure(2047, -3, 0, 0);
    send_frame(12, 1, 0, 0, 0);
  endtask

  task automatic test_full_disparity_range;
    configure(73, -64, 0, 16384);
    no_idle = 1'b1;
    send_frame(73, 9, 40, 5, 0);
    no_idle = 1'b0;
  endtask

  task automatic test_empty_range;
    configure(11, -2, -3, -32768);
    hold_req = 1'b1;
    send_frame(11, 10, 1, 0, 0);
    configure(11, 0, -64, 0);
    send_frame(11, 9, 0, 0, 0);
  endtask

  task automatic test_random_frames;
    int w, dmin, dmax, thr, rows, shift, frame_no, rnd;
    frame_no = 0;
    while (pixels_sent < 1700) begin
      w = ($urandom_range(9) == 0) ? 9 : $urandom_range(10, 20);
      dmin = -$urandom_range(0, 8);
      rnd = $urandom_range(99);
      if (rnd < 6) dmax = dmin - 1;
      else if (rnd < 12) dmax = $urandom_range(1, 63);
      else dmax = dmin + $urandom_range(0, 3);
      if (dmax > 63) dmax = 63;
      rnd = $urandom_range(9);
      thr = (rnd == 0) ? -32768 : (rnd == 1) ? 32767 : $urandom_range(0, 65535);
      configure(w, dmin, dmax, thr);
      rows = $urandom_range(9, 13);
      shift = -dmin - $urandom_range(0, 2);
      if (shift < 0) shift = 0;
      no_idle = (frame_no % 7 == 5);
      if ($urandom_range(9) == 0)
        send_frame(w, $urandom_range(2, 9), shift, 10, 0);
      else
        send_frame(w, rows, shift, ($urandom_range(5) == 0) ? 100 : 8,
                   ($urandom_range(11) == 0) ? 3 : 0);
      frame_no++;
    end
    no_idle = 1'b0;
  endtask

  initial begin
    col_cnt = 0;
    row_cnt = 0;
    cfg_width = RST_WIDTH;
    cfg_dmin = RST_DMIN;
    cfg_dmax = RST_DMAX;
    cfg_thresh = RST_THRESH;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_register_access();
    test_corner_frames();
    test_full_disparity_range();
    test_empty_range();
    test_random_frames();
    drain();
    repeat (200) @(posedge clk_i);
    if (err_count == 0 && expected_matches.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

// ----- files.f -----
hw/rtl/nsd_pkg.sv
hw/rtl/ncc_stereo_disparity_unit.sv
tb/sv/tb_top.sv
